[rtl/rfc_pkg.sv]
// Shared types, character codes and constants of the RPN float stack calculator.
`timescale 1ns / 1ps

package rfc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 8;
    localparam int CMD_FIFO_DEPTH      = 4;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NEG   = 8'h6E;
    localparam logic [7:0] CH_PRINT = 8'h70;
    localparam logic [7:0] CH_DUP   = 8'h64;
    localparam logic [7:0] CH_CLEAR = 8'h63;
    localparam logic [7:0] CH_QUIT  = 8'h71;

    localparam logic [31:0] FLOAT_QNAN = 32'h7FC0_0000;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_NEG   = 4'd5,
        OP_DUP   = 4'd6,
        OP_PRINT = 4'd7,
        OP_CLEAR = 4'd8
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic v0;
        cmd_t d0;
        logic v1;
        cmd_t d1;
    } cmd_push_t;

endpackage

[rtl/rfc_front.sv]
// Character front end: builds numbers and turns each character into stack commands.
`timescale 1ns / 1ps

module rfc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // char_code
    input  logic                room2,
    output rfc_pkg::cmd_push_t  push
);

    logic        active_reg, active_next;
    logic        negative_reg, negative_next;
    logic        minus_reg, minus_next;
    logic        halted_reg, halted_next;
    logic [31:0] acc_reg, acc_next;

    logic          accept;
    logic          is_digit;
    logic [7:0]    digit_val;
    logic          cont;
    logic          emit_a, emit_b;
    rfc_pkg::cmd_t cmd_a, cmd_b;

    assign s_axis_tready = halted_reg | room2;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign is_digit      = (s_axis_tdata >= rfc_pkg::CH_0) && (s_axis_tdata <= rfc_pkg::CH_9);
    assign digit_val     = s_axis_tdata - rfc_pkg::CH_0;

    always_comb
    begin
        active_next   = active_reg;
        negative_next = negative_reg;
        minus_next    = minus_reg;
        halted_next   = halted_reg;
        acc_next      = acc_reg;
        emit_a        = 1'b0;
        emit_b        = 1'b0;
        cmd_a         = '{op: rfc_pkg::OP_PUSH, value: 32'd0};
        cmd_b         = '{op: rfc_pkg::OP_PUSH, value: 32'd0};
        cont          = 1'b1;
        if (accept && !halted_reg)
        begin
            if (active_reg)
            begin
                if (is_digit)
                begin
                    acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0}
                               + {28'd0, digit_val[3:0]};
                    cont     = 1'b0;
                end
                else
                begin
                    emit_a        = 1'b1;
                    cmd_a.op      = rfc_pkg::OP_PUSH;
                    cmd_a.value   = negative_reg ? (~acc_reg + 32'd1) : acc_reg;
                    active_next   = 1'b0;
                    negative_next = 1'b0;
                    acc_next      = 32'd0;
                end
            end
            else if (minus_reg)
            begin
                minus_next = 1'b0;
                if (is_digit)
                begin
                    active_next   = 1'b1;
                    negative_next = 1'b1;
                    acc_next      = {28'd0, digit_val[3:0]};
                    cont          = 1'b0;
                end
                else
                begin
                    emit_a   = 1'b1;
                    cmd_a.op = rfc_pkg::OP_SUB;
                end
            end
            if (cont)
            begin
                if (is_digit)
                begin
                    active_next   = 1'b1;
                    negative_next = 1'b0;
                    acc_next      = {28'd0, digit_val[3:0]};
                end
                else
                begin
                    case (s_axis_tdata)
                        rfc_pkg::CH_MINUS: minus_next = 1'b1;
                        rfc_pkg::CH_PLUS:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_ADD;
                        end
                        rfc_pkg::CH_STAR:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_MUL;
                        end
                        rfc_pkg::CH_SLASH:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_DIV;
                        end
                        rfc_pkg::CH_NEG:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_NEG;
                        end
                        rfc_pkg::CH_DUP:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_DUP;
                        end
                        rfc_pkg::CH_PRINT:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_PRINT;
                        end
                        rfc_pkg::CH_CLEAR:
                        begin
                            emit_b   = 1'b1;
                            cmd_b.op = rfc_pkg::OP_CLEAR;
                        end
                        rfc_pkg::CH_QUIT:  halted_next = 1'b1;
                        default:           halted_next = halted_reg;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        push.v0 = emit_a | emit_b;
        push.d0 = emit_a ? cmd_a : cmd_b;
        push.v1 = emit_a & emit_b;
        push.d1 = cmd_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            negative_reg <= 1'b0;
            minus_reg    <= 1'b0;
            halted_reg   <= 1'b0;
            acc_reg      <= 32'd0;
        end
        else
        begin
            active_reg   <= active_next;
            negative_reg <= negative_next;
            minus_reg    <= minus_next;
            halted_reg   <= halted_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

[rtl/rfc_cmd_fifo.sv]
// Short command queue between the front end and the stack engine, taking up to two commands a cycle.
`timescale 1ns / 1ps

module rfc_cmd_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  rfc_pkg::cmd_push_t push,
    output logic               room2,
    input  logic               pop,
    output logic               not_empty,
    output rfc_pkg::cmd_t      head
);

    localparam int DEPTH = rfc_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfc_pkg::cmd_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign room2        = (count_reg <= CNT_W'(DEPTH - 2));
    assign not_empty    = (count_reg != '0);
    assign head         = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.v0) + PTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            entries[wr_ptr_reg] <= push.d0;
        end
        if (push.v1)
        begin
            entries[wr_ptr_plus1] <= push.d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rfc_back.sv]
// Stack engine: value stack memory and an iterative single-precision arithmetic sequencer.
`timescale 1ns / 1ps

module rfc_back
#(
    parameter int STACK_DEPTH = rfc_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  rfc_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [39:0]   m_axis_tdata    // print_value, stack_fault
);

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_RDB   = 15'b000000000000010,
        S_SPEC  = 15'b000000000000100,
        S_ADD   = 15'b000000000001000,
        S_PREN  = 15'b000000000010000,
        S_MUL   = 15'b000000000100000,
        S_MULF  = 15'b000000001000000,
        S_DIVI  = 15'b000000010000000,
        S_DIV   = 15'b000000100000000,
        S_CVT   = 15'b000001000000000,
        S_NORM  = 15'b000010000000000,
        S_WRITE = 15'b000100000000000,
        S_NEG   = 15'b001000000000000,
        S_DUP   = 15'b010000000000000,
        S_PRINT = 15'b100000000000000
    } state_t;

    function automatic logic [23:0] mant_of(input logic [31:0] f);
        return {f[30:23] != 8'd0, f[22:0]};
    endfunction

    function automatic logic signed [10:0] exp_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, f[30:23]});
    endfunction

    function automatic logic [31:0] to_int(input logic [31:0] f);
        logic [7:0]  e;
        logic [31:0] m32;
        logic [31:0] mag;
        e   = f[30:23];
        m32 = {8'd0, 1'b1, f[22:0]};
        mag = (e >= 8'd150) ? (m32 << (e - 8'd150)) : (m32 >> (8'd150 - e));
        if (e == 8'hFF && f[22:0] != 23'd0)
        begin
            return 32'd0;
        end
        else if (e >= 8'd158)
        begin
            return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (e < 8'd127)
        begin
            return 32'd0;
        end
        return f[31] ? (~mag + 32'd1) : mag;
    endfunction

    logic [31:0] value_mem [STACK_DEPTH];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                fault_reg, fault_next;
    rfc_pkg::op_t        op_reg, op_next;
    logic [31:0]         rd_data_reg;
    logic [31:0]         b_reg, b_next;
    logic                sign_reg, sign_next;
    logic                eff_sub_reg, eff_sub_next;
    logic                zero_plus_reg, zero_plus_next;
    logic signed [10:0]  ea_reg, ea_next, eb_reg, eb_next, e_reg, e_next;
    logic [23:0]         ma_reg, ma_next, mb_reg, mb_next;
    logic [27:0]         m_reg, m_next;
    logic [47:0]         prod_reg, prod_next;
    logic [25:0]         rem_reg, rem_next, quo_reg, quo_next;
    logic [4:0]          iter_reg, iter_next;
    logic [31:0]         cvt_reg, cvt_next;
    logic [31:0]         res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_value_reg, out_value_next;
    logic                out_fault_reg, out_fault_next;

    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;
    logic                stack_full;

    logic [31:0]         fa, fb;
    logic                sa, sbe, sbm;
    logic                a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic signed [10:0]  diff;
    logic [4:0]          shamt;
    logic [63:0]         ext;
    logic [26:0]         aligned;
    logic                div_ge;
    logic [25:0]         div_rem;
    logic [24:0]         rnd_sum;
    logic                rnd_up;
    logic signed [10:0]  rnd_e;

    assign cnt_m1       = count_reg - CNT_W'(1);
    assign cnt_m2       = count_reg - CNT_W'(2);
    assign stack_full   = (count_reg == CNT_W'(STACK_DEPTH));
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_fault_reg, out_value_reg};

    assign fa     = rd_data_reg;
    assign fb     = b_reg;
    assign sa     = fa[31];
    assign sbm    = fb[31];
    assign sbe    = fb[31] ^ (op_reg == rfc_pkg::OP_SUB);
    assign a_nan  = (fa[30:23] == 8'hFF) && (fa[22:0] != 23'd0);
    assign b_nan  = (fb[30:23] == 8'hFF) && (fb[22:0] != 23'd0);
    assign a_inf  = (fa[30:23] == 8'hFF) && (fa[22:0] == 23'd0);
    assign b_inf  = (fb[30:23] == 8'hFF) && (fb[22:0] == 23'd0);
    assign a_zero = (fa[30:0] == 31'd0);
    assign b_zero = (fb[30:0] == 31'd0);
    assign a_big  = (fa[30:0] >= fb[30:0]);

    assign diff    = ea_reg - eb_reg;
    assign shamt   = (diff > 11'sd31) ? 5'd31 : diff[4:0];
    assign ext     = {mb_reg, 3'b000, 37'd0} >> shamt;
    assign aligned = {ext[63:38], ext[37] | (|ext[36:0])};

    assign div_ge  = (rem_reg >= {2'b00, mb_reg});
    assign div_rem = div_ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;

    assign rnd_up  = m_reg[2] & (m_reg[1] | m_reg[0] | m_reg[3]);
    assign rnd_sum = {1'b0, m_reg[26:3]} + {24'd0, rnd_up};
    assign rnd_e   = e_reg + $signed({10'd0, rnd_sum[24]});

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fault_next     = fault_reg;
        op_next        = op_reg;
        b_next         = b_reg;
        sign_next      = sign_reg;
        eff_sub_next   = eff_sub_reg;
        zero_plus_next = zero_plus_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        e_next         = e_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        cvt_next       = cvt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_value_next = out_value_reg;
        out_fault_next = out_fault_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_raddr      = cnt_m1[IDX_W-1:0];
        mem_wdata      = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    op_next = cmd.op;
                    case (cmd.op)
                        rfc_pkg::OP_PUSH:
                        begin
                            if (stack_full)
                            begin
                                fault_next = 1'b1;
                            end
                            else if (cmd.value == 32'd0)
                            begin
                                res_next   = 32'd0;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                sign_next  = cmd.value[31];
                                cvt_next   = cmd.value[31] ? (~cmd.value + 32'd1) : cmd.value;
                                e_next     = 11'sd158;
                                state_next = S_CVT;
                            end
                        end
                        rfc_pkg::OP_ADD, rfc_pkg::OP_SUB, rfc_pkg::OP_MUL, rfc_pkg::OP_DIV:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_RDB;
                            end
                        end
                        rfc_pkg::OP_NEG:
                        begin
                            if (count_reg == '0)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_NEG;
                            end
                        end
                        rfc_pkg::OP_DUP:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (stack_full)
                            begin
                                fault_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_DUP;
                            end
                        end
                        rfc_pkg::OP_PRINT:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re     = 1'b1;
                                state_next = S_PRINT;
                            end
                        end
                        rfc_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            fault_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RDB:
            begin
                b_next     = rd_data_reg;
                mem_re     = 1'b1;
                mem_raddr  = cnt_m2[IDX_W-1:0];
                state_next = S_SPEC;
            end

            S_SPEC:
            begin
                zero_plus_next = 1'b0;
                state_next     = S_WRITE;
                case (op_reg)
                    rfc_pkg::OP_ADD, rfc_pkg::OP_SUB:
                    begin
                        if (a_nan || b_nan)
                        begin
                            res_next = rfc_pkg::FLOAT_QNAN;
                        end
                        else if (a_inf && b_inf)
                        begin
                            res_next = (sa == sbe) ? {sa, 8'hFF, 23'd0} : rfc_pkg::FLOAT_QNAN;
                        end
                        else if (a_inf)
                        begin
                            res_next = {sa, 8'hFF, 23'd0};
                        end
                        else if (b_inf)
                        begin
                            res_next = {sbe, 8'hFF, 23'd0};
                        end
                        else if (a_zero && b_zero)
                        begin
                            res_next = {sa & sbe, 31'd0};
                        end
                        else
                        begin
                            zero_plus_next = 1'b1;
                            eff_sub_next   = sa ^ sbe;
                            sign_next      = a_big ? sa : sbe;
                            ma_next        = a_big ? mant_of(fa) : mant_of(fb);
                            ea_next        = a_big ? exp_of(fa) : exp_of(fb);
                            mb_next        = a_big ? mant_of(fb) : mant_of(fa);
                            eb_next        = a_big ? exp_of(fb) : exp_of(fa);
                            state_next     = S_ADD;
                        end
                    end
                    rfc_pkg::OP_MUL:
                    begin
                        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            res_next = rfc_pkg::FLOAT_QNAN;
                        end
                        else if (a_inf || b_inf)
                        begin
                            res_next = {sa ^ sbm, 8'hFF, 23'd0};
                        end
                        else if (a_zero || b_zero)
                        begin
                            res_next = {sa ^ sbm, 31'd0};
                        end
                        else
                        begin
                            sign_next  = sa ^ sbm;
                            ma_next    = mant_of(fa);
                            ea_next    = exp_of(fa);
                            mb_next    = mant_of(fb);
                            eb_next    = exp_of(fb);
                            state_next = S_PREN;
                        end
                    end
                    default:
                    begin
                        if (b_zero)
                        begin
                            res_next = (a_nan || a_zero) ? rfc_pkg::FLOAT_QNAN
                                                         : {sa ^ sbm, 8'hFF, 23'd0};
                        end
                        else if (a_nan || b_nan || (a_inf && b_inf))
                        begin
                            res_next = rfc_pkg::FLOAT_QNAN;
                        end
                        else if (a_inf)
                        begin
                            res_next = {sa ^ sbm, 8'hFF, 23'd0};
                        end
                        else if (b_inf || a_zero)
                        begin
                            res_next = {sa ^ sbm, 31'd0};
                        end
                        else
                        begin
                            sign_next  = sa ^ sbm;
                            ma_next    = mant_of(fa);
                            ea_next    = exp_of(fa);
                            mb_next    = mant_of(fb);
                            eb_next    = exp_of(fb);
                            state_next = S_PREN;
                        end
                    end
                endcase
            end

            S_ADD:
            begin
                m_next     = eff_sub_reg ? ({1'b0, ma_reg, 3'b000} - {1'b0, aligned})
                                         : ({1'b0, ma_reg, 3'b000} + {1'b0, aligned});
                e_next     = ea_reg;
                state_next = S_NORM;
            end

            S_PREN:
            begin
                if (!ma_reg[23])
                begin
                    ma_next = {ma_reg[22:0], 1'b0};
                    ea_next = ea_reg - 11'sd1;
                end
                if (!mb_reg[23])
                begin
                    mb_next = {mb_reg[22:0], 1'b0};
                    eb_next = eb_reg - 11'sd1;
                end
                if (ma_reg[23] && mb_reg[23])
                begin
                    state_next = (op_reg == rfc_pkg::OP_MUL) ? S_MUL : S_DIVI;
                end
            end

            S_MUL:
            begin
                prod_next  = ma_reg * mb_reg;
                e_next     = ea_reg + eb_reg - 11'sd127;
                state_next = S_MULF;
            end

            S_MULF:
            begin
                m_next     = {prod_reg[47:21], |prod_reg[20:0]};
                state_next = S_NORM;
            end

            S_DIVI:
            begin
                if (ma_reg < mb_reg)
                begin
                    rem_next = {1'b0, ma_reg, 1'b0};
                    e_next   = ea_reg - eb_reg + 11'sd126;
                end
                else
                begin
                    rem_next = {2'b00, ma_reg};
                    e_next   = ea_reg - eb_reg + 11'sd127;
                end
                quo_next   = '0;
                iter_next  = 5'd25;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                quo_next  = {quo_reg[24:0], div_ge};
                rem_next  = {div_rem[24:0], 1'b0};
                iter_next = iter_reg - 5'd1;
                if (iter_reg == 5'd0)
                begin
                    m_next     = {1'b0, quo_reg[24:0], div_ge, div_rem != 26'd0};
                    state_next = S_NORM;
                end
            end

            S_CVT:
            begin
                if (cvt_reg[31])
                begin
                    m_next     = {1'b0, cvt_reg[31:6], |cvt_reg[5:0]};
                    state_next = S_NORM;
                end
                else
                begin
                    cvt_next = {cvt_reg[30:0], 1'b0};
                    e_next   = e_reg - 11'sd1;
                end
            end

            S_NORM:
            begin
                if (m_reg[27])
                begin
                    m_next = {1'b0, m_reg[27:2], m_reg[1] | m_reg[0]};
                    e_next = e_reg + 11'sd1;
                end
                else if (e_reg < 11'sd1)
                begin
                    if (e_reg < -11'sd30)
                    begin
                        m_next = {27'd0, |m_reg};
                        e_next = 11'sd1;
                    end
                    else
                    begin
                        m_next = {1'b0, m_reg[27:2], m_reg[1] | m_reg[0]};
                        e_next = e_reg + 11'sd1;
                    end
                end
                else if (!m_reg[26] && (e_reg > 11'sd1) && (m_reg != 28'd0))
                begin
                    m_next = {m_reg[26:0], 1'b0};
                    e_next = e_reg - 11'sd1;
                end
                else
                begin
                    if (m_reg == 28'd0 && zero_plus_reg)
                    begin
                        res_next = 32'd0;
                    end
                    else if (rnd_e >= 11'sd255)
                    begin
                        res_next = {sign_reg, 8'hFF, 23'd0};
                    end
                    else if (rnd_sum[24])
                    begin
                        res_next = {sign_reg, rnd_e[7:0], 23'd0};
                    end
                    else
                    begin
                        res_next = {sign_reg, rnd_sum[23] ? rnd_e[7:0] : 8'd0, rnd_sum[22:0]};
                    end
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = res_reg;
                if (op_reg == rfc_pkg::OP_PUSH)
                begin
                    mem_waddr  = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    mem_waddr  = cnt_m2[IDX_W-1:0];
                    count_next = cnt_m1;
                end
                state_next = S_IDLE;
            end

            S_NEG:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_m1[IDX_W-1:0];
                mem_wdata  = {~rd_data_reg[31], rd_data_reg[30:0]};
                state_next = S_IDLE;
            end

            S_DUP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[IDX_W-1:0];
                mem_wdata  = rd_data_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_IDLE;
            end

            S_PRINT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = to_int(rd_data_reg);
                    out_fault_next = fault_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= value_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg         <= b_next;
        sign_reg      <= sign_next;
        eff_sub_reg   <= eff_sub_next;
        zero_plus_reg <= zero_plus_next;
        ea_reg        <= ea_next;
        eb_reg        <= eb_next;
        e_reg         <= e_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        m_reg         <= m_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        iter_reg      <= iter_next;
        cvt_reg       <= cvt_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_fault_reg <= out_fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            op_reg        <= rfc_pkg::OP_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fault_reg     <= fault_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && op_reg != rfc_pkg::OP_PUSH)
        |=> (count_reg == $past(cnt_m1)))
        else $error("An arithmetic result did not leave the stack one entry shorter.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == rfc_pkg::OP_CLEAR) |=> (count_reg == '0 && !fault_reg))
        else $error("Clear did not empty the stack and drop the fault flag.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && iter_reg == 5'd0) |=> (state_reg == S_NORM))
        else $error("Division did not hand over to normalisation after its last step.");

endmodule

[rtl/rpn_float_stack_calculator.sv]
// Top level of the RPN single-precision stack calculator.
//
// Characters enter on the s_axis channel, one per transfer; results of p leave on
// the m_axis channel. The front end takes a character whenever the command queue has
// room for two commands, so input is stalled only while the stack engine is behind. A
// character becomes zero, one or two commands, written into the queue in the same
// cycle as its transfer. The stack engine runs one command at a time: clear acts as
// it is taken from the queue; negate, duplicate and print read the top entry first;
// a number push shifts out the leading zero bits of its magnitude, then normalises;
// add and subtract align, add and normalise; multiply and divide pre-normalise, then
// multiply or divide and normalise. The divider retires one quotient bit a cycle, the
// normaliser shifts one bit a cycle, and subnormal multiply and divide operands are
// pre-normalised one bit at a time. A print result sits in an output register until
// taken; the engine carries on with later commands and stalls only when a second
// print finds the register full. Reset empties the stack, clears the fault flag and
// the number being built, and leaves the output channel idle. After q every further
// character is taken and ignored until reset.
`timescale 1ns / 1ps

module rpn_float_stack_calculator
#(
    parameter int STACK_DEPTH = rfc_pkg::DEFAULT_STACK_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // print_value [31:0], stack_fault [32]
);

    rfc_pkg::cmd_push_t push;
    rfc_pkg::cmd_t      head;
    logic               room2;
    logic               not_empty;
    logic               cmd_pop;

    rfc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .room2         (room2),
        .push          (push)
    );

    rfc_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .pop       (cmd_pop),
        .not_empty (not_empty),
        .head      (head)
    );

    rfc_back
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (not_empty),
        .cmd           (head),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
